@@ sv/tpg_pkg.sv @@
package tpg_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_W     = 3;
	localparam int PHYS_W   = 8;
	localparam int MUTE_W   = 6;
	localparam int MODE_W   = 3;
	localparam int PEND_W   = 8;
	localparam int CD_W     = 7;
	localparam int LEN_W    = 5;
	localparam int CFG_W    = 6;

	// Channel six loads a fixed ten-tick countdown whenever it fires a pending pulse
	localparam logic [CH_W-1:0] FIXED_CH     = 3'd6;
	localparam logic [CD_W-1:0] FIXED_CH_LEN = 7'd10;

	localparam logic [PEND_W-1:0] PEND_MAX = 8'd255;

	localparam logic [31:0] RNG_X_INIT = 32'd170;
	localparam logic [31:0] RNG_Y_INIT = 32'd229;
	localparam logic [31:0] RNG_Z_INIT = 32'd181;
	localparam logic [31:0] RAND_MASK  = 32'h0000_FFFF;

	localparam logic [MUTE_W-1:0] MUTE_RESET = 6'd63;
	localparam logic [MODE_W-1:0] MODE_RESET = 3'd0;

	// Channel to physical output bit
	localparam logic [2:0] CHAN_MAP [0:7] = '{3'd2, 3'd4, 3'd3, 3'd7, 3'd6, 3'd5, 3'd0, 3'd1};

	// Fixed lengths for modes 0..3
	localparam logic [LEN_W-1:0] FIXED_LEN [0:3] = '{5'd1, 5'd5, 5'd10, 5'd20};

	// Random range bounds for modes 4..7, upper bound exclusive
	localparam logic [LEN_W-1:0] RAND_LO [0:3] = '{5'd1, 5'd5, 5'd10, 5'd1};
	localparam logic [LEN_W-1:0] RAND_HI [0:3] = '{5'd5, 5'd10, 5'd20, 5'd20};

	typedef enum logic [0:0] {
		REG_LENGTH_MODE = 1'b0,
		REG_MUTE_MASK   = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SET,
		ST_TICK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic            cmd;
		logic [CH_W-1:0] channel;
		logic            fire;
		logic            auto_off;
	} in_beat_t;

	typedef struct packed {
		logic [PHYS_W-1:0] trig_out;
		logic [PHYS_W-1:0] trig_raw;
	} out_beat_t;

	typedef struct packed {
		logic [PEND_W-1:0] pending;
		logic [CD_W-1:0]   countdown;
	} entry_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} rng_t;

	// One xorshift96 step
	function automatic rng_t rng_step(rng_t s);
		logic [31:0] t;
		rng_t        n;
		t = s.x;
		t = t ^ (t << 16);
		t = t ^ (t >> 5);
		t = t ^ (t << 1);
		n.x = s.y;
		n.y = s.z;
		n.z = t ^ s.y ^ s.z;
		return n;
	endfunction

	// Scale a 16-bit draw into the range of a random mode
	function automatic logic [LEN_W-1:0] rand_len(logic [1:0] sel, logic [31:0] r);
		logic [15:0]      r16;
		logic [LEN_W-1:0] span;
		logic [20:0]      prod;
		r16  = r[15:0] & RAND_MASK[15:0];
		span = RAND_HI[sel] - RAND_LO[sel];
		prod = 21'(r16) * 21'(span);
		return RAND_LO[sel] + prod[20:16];
	endfunction

	function automatic logic [PHYS_W-1:0] phys_bit(logic [CH_W-1:0] ch);
		return PHYS_W'(1) << CHAN_MAP[ch];
	endfunction

	// Physical bits that pass; channels six and seven are never muted
	function automatic logic [PHYS_W-1:0] audible(logic [MUTE_W-1:0] mute);
		logic [PHYS_W-1:0] m;
		m = '1;
		for (int i = 0; i < MUTE_W; i++) begin
			m[CHAN_MAP[i]] = mute[i];
		end
		return m;
	endfunction

endpackage

@@ sv/tpg_ram.sv @@
module tpg_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ sv/trigger_pulse_generator.sv @@
// Channel  Dir  Beat type             Handshake
// in       in   tpg_pkg::in_beat_t    in_valid / in_stall
// out      out  tpg_pkg::out_beat_t   out_valid / out_stall
// cfg      in   index + data          cfg_wr_en, no wait
//
// A set-trigger beat reads the channel entry, modifies and writes it back, then loads the
// result register. A tick beat does one read-modify-write per channel on the one-read
// one-write entry RAM, reading the next channel while writing this one, then loads the result.
// Reset clears control state and the entry valid bits; no clearing pass is needed.
// A stalled result holds in the output register; the next beat is taken meanwhile and its
// result waits in the finish state until the register frees up.
module trigger_pulse_generator #(
	parameter int CHANNELS = tpg_pkg::CHANNELS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  tpg_pkg::in_beat_t                in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output tpg_pkg::out_beat_t               out_data,
	input  logic                             cfg_wr_en,
	input  tpg_pkg::reg_idx_t                cfg_index,
	input  logic [tpg_pkg::CFG_W-1:0]        cfg_data
);

	import tpg_pkg::*;

	localparam int AW = $clog2(CHANNELS);

	state_t            state_q, state_d;
	logic [AW-1:0]     ch_q, ch_d;
	in_beat_t          item_q;
	logic [PHYS_W-1:0] out_bits_q, out_bits_d;
	logic [CHANNELS-1:0] ao_bits_q, ao_bits_d;
	rng_t              rng_q, rng_d, rng_adv;
	logic [MODE_W-1:0] mode_q;
	logic [MUTE_W-1:0] mute_q;
	logic [CHANNELS-1:0] valid_q;
	logic              rd_ok_s1;
	out_beat_t         out_q;
	logic              out_valid_q;

	logic              in_acc;
	logic              out_load;
	logic              wr_en;
	logic [AW-1:0]     wr_addr, rd_addr;
	entry_t            wr_data, rd_data, ent;
	logic [LEN_W-1:0]  len;
	logic [CH_W-1:0]   cur_ch;
	logic [PHYS_W-1:0] pb;
	logic              ao;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	tpg_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (CHANNELS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Entries never written read as zero
	assign ent = rd_ok_s1 ? rd_data : '0;

	// Pulse length for the current draw
	assign rng_adv = rng_step(rng_q);
	assign len     = mode_q[2] ? rand_len(mode_q[1:0], rng_adv.z) : FIXED_LEN[mode_q[1:0]];

	assign cur_ch = (state_q == ST_TICK) ? CH_W'(ch_q) : item_q.channel;
	assign pb     = phys_bit(cur_ch);
	assign ao     = ao_bits_q[cur_ch[AW-1:0]];

	// Sequencer: next state, read-modify-write of the entry
	always_comb begin
		state_d    = state_q;
		ch_d       = ch_q;
		out_bits_d = out_bits_q;
		ao_bits_d  = ao_bits_q;
		rng_d      = rng_q;
		wr_en      = 1'b0;
		wr_addr    = cur_ch[AW-1:0];
		wr_data    = ent;
		rd_addr    = '0;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = in_data.cmd ? in_data.channel[AW-1:0] : '0;
				ch_d    = '0;
				if (in_acc) begin
					state_d = in_data.cmd ? ST_SET : ST_TICK;
				end
			end
			ST_SET: begin
				wr_en = 1'b1;
				ao_bits_d[cur_ch[AW-1:0]] = item_q.auto_off;
				if (item_q.fire) begin
					if (ent.pending != PEND_MAX) begin
						wr_data.pending = ent.pending + PEND_W'(1);
					end
				end else if (!mode_q[2]) begin
					out_bits_d = out_bits_q & ~pb;
				end else begin
					wr_data.countdown = CD_W'({len, 2'b00});
					rng_d = rng_adv;
					ao_bits_d[cur_ch[AW-1:0]] = 1'b1;
				end
				state_d = ST_FINISH;
			end
			ST_TICK: begin
				wr_en   = 1'b1;
				rd_addr = ch_q + AW'(1);
				ch_d    = ch_q + AW'(1);
				if (ent.pending != '0) begin
					if (((out_bits_q & pb) != '0) && ao) begin
						// drop the raised bit for one tick first
						out_bits_d = out_bits_q & ~pb;
					end else begin
						out_bits_d      = out_bits_q | pb;
						wr_data.pending = ent.pending - PEND_W'(1);
						if (cur_ch == FIXED_CH) begin
							wr_data.countdown = FIXED_CH_LEN;
						end else begin
							wr_data.countdown = CD_W'(len);
							if (mode_q[2]) begin
								rng_d = rng_adv;
							end
						end
					end
				end else if (ent.countdown != '0) begin
					if ((ent.countdown == CD_W'(1)) && ao) begin
						out_bits_d = out_bits_q & ~pb;
					end
					wr_data.countdown = ent.countdown - CD_W'(1);
				end
				if (ch_q == AW'(CHANNELS - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			out_bits_q  <= '0;
			ao_bits_q   <= '0;
			rng_q       <= '{x: RNG_X_INIT, y: RNG_Y_INIT, z: RNG_Z_INIT};
			mode_q      <= MODE_RESET;
			mute_q      <= MUTE_RESET;
			valid_q     <= '0;
			rd_ok_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			ch_q       <= ch_d;
			out_bits_q <= out_bits_d;
			ao_bits_q  <= ao_bits_d;
			rng_q      <= rng_d;
			rd_ok_s1   <= valid_q[rd_addr];
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_LENGTH_MODE: mode_q <= cfg_data[MODE_W-1:0];
					REG_MUTE_MASK:   mute_q <= cfg_data[MUTE_W-1:0];
					default:         mode_q <= mode_q;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_data;
		end
		if (out_load) begin
			out_q.trig_raw <= out_bits_q;
			out_q.trig_out <= out_bits_q & audible(mute_q);
		end
	end

	// Beats are taken only when the sequencer is idle
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (state_q == ST_IDLE))
		else $error("beat accepted while busy");

	// A tick starts its channel walk at channel zero
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !in_data.cmd) |=> (state_q == ST_TICK && ch_q == '0))
		else $error("tick walk did not start at channel zero");

	// Entry RAM is written only from the modify states
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_SET || state_q == ST_TICK))
		else $error("entry write outside modify state");

	// Muted output never sets a bit the raw output lacks
	a_mute_subset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_q.trig_out & ~out_q.trig_raw) == '0))
		else $error("muted output exceeds raw output");

	// A result is loaded only after the last step of an item
	a_load_finish: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> ($past(state_q) == ST_SET || $past(state_q) == ST_TICK
			|| $past(state_q) == ST_FINISH))
		else $error("result loaded out of sequence");

endmodule
